@@ hdl/pgps_pkg.sv @@
`default_nettype none

package pgps_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SEED   = 3'd1,
        PH_PPLUS  = 3'd2,
        PH_PMINUS = 3'd3,
        PH_DPLUS  = 3'd4,
        PH_DMINUS = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_SCORE = 1'b1;

    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_START_GAIN_P    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_GAIN_D    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_FRACTION   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_STEP        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SHRINK_FACTOR   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT = 3'd5;

    localparam logic [31:0] RST_START_GAIN_P    = 32'd65536;
    localparam logic [31:0] RST_START_GAIN_D    = 32'd0;
    localparam logic [15:0] RST_STEP_FRACTION   = 16'd13107;
    localparam logic [31:0] RST_MIN_STEP        = 32'd655;
    localparam logic [15:0] RST_SHRINK_FACTOR   = 16'd32768;
    localparam logic [7:0]  RST_ITERATION_LIMIT = 8'd20;

    typedef struct packed {
        logic [31:0] start_gain_p;
        logic [31:0] start_gain_d;
        logic [15:0] step_fraction;
        logic [31:0] min_step;
        logic [15:0] shrink_factor;
        logic [7:0]  iteration_limit;
    } cfg_t;

    typedef struct packed {
        logic [31:0] gain_p;
        logic [31:0] gain_d;
        logic [31:0] best;
        logic [31:0] seed;
        logic [31:0] step_p;
        logic [31:0] step_d;
        logic [7:0]  iter;
        phase_t      phase;
        logic        improved;
        logic        parity;
    } state_t;

    typedef struct packed {
        logic        finished;
        logic [31:0] gain_p;
        logic [31:0] gain_d;
        logic        reverse_direction;
        logic [31:0] best_cost;
        logic [31:0] seed_cost;
        logic [7:0]  iterations_done;
    } result_t;

    typedef struct packed {
        logic   found;
        phase_t phase;
    } probe_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Q16.16 times Q0.16, floor
    function automatic logic [31:0] qmul16(input logic [31:0] a, input logic [15:0] f);
        logic [47:0] p;
        p = {16'd0, a} * {32'd0, f};
        return p[47:16];
    endfunction

endpackage

`default_nettype wire

@@ hdl/pgps_step.sv @@
`default_nettype none

module pgps_step (
    input  wire pgps_pkg::state_t  cur,
    input  wire pgps_pkg::cfg_t    cfg,
    input  wire logic              cmd,
    input  wire logic [31:0]       score,
    output pgps_pkg::state_t       nxt,
    output pgps_pkg::result_t      res,
    output logic                   res_valid
);

    function automatic pgps_pkg::probe_t find_probe(
        input pgps_pkg::phase_t from,
        input logic [31:0]      gp,
        input logic [31:0]      gd,
        input logic [31:0]      sp,
        input logic [31:0]      sd
    );
        pgps_pkg::probe_t r;
        r.found = 1'b1;
        r.phase = pgps_pkg::PH_DPLUS;
        if (from <= pgps_pkg::PH_PPLUS && pgps_pkg::sat_add(gp, sp) != 32'd0)
            r.phase = pgps_pkg::PH_PPLUS;
        else if (from <= pgps_pkg::PH_PMINUS && gp > sp)
            r.phase = pgps_pkg::PH_PMINUS;
        else if (from <= pgps_pkg::PH_DPLUS)
            r.phase = pgps_pkg::PH_DPLUS;
        else if (from == pgps_pkg::PH_DMINUS && gd >= sd)
            r.phase = pgps_pkg::PH_DMINUS;
        else
            r.found = 1'b0;
        return r;
    endfunction

    // one multiplier per axis: seed step on start, shrink otherwise
    logic [31:0] mul_a_p;
    logic [31:0] mul_a_d;
    logic [15:0] mul_f;
    logic [31:0] prod_p;
    logic [31:0] prod_d;

    logic [31:0] w_gp;
    logic [31:0] w_gd;
    logic [31:0] w_sp;
    logic [31:0] w_sd;
    logic [7:0]  w_iter;
    logic [31:0] w_best;
    logic [31:0] w_seed;
    logic        w_improved;
    logic        entry_restart;
    logic        go_search;
    logic        go_close;
    logic        emit_final;
    logic        emit_probe;
    logic        emit_done;
    logic        improve;
    pgps_pkg::phase_t search_from;
    pgps_pkg::probe_t probe;
    logic [31:0] cand;

    always_comb
    begin
        if (cmd == pgps_pkg::CMD_START)
        begin
            mul_a_p = cfg.start_gain_p;
            mul_a_d = cfg.start_gain_d;
            mul_f   = cfg.step_fraction;
        end
        else
        begin
            mul_a_p = cur.step_p;
            mul_a_d = cur.step_d;
            mul_f   = cfg.shrink_factor;
        end
        prod_p = pgps_pkg::qmul16(mul_a_p, mul_f);
        prod_d = pgps_pkg::qmul16(mul_a_d, mul_f);
    end

    always_comb
    begin
        nxt           = cur;
        res           = '0;
        res_valid     = 1'b0;
        w_gp          = cur.gain_p;
        w_gd          = cur.gain_d;
        w_sp          = cur.step_p;
        w_sd          = cur.step_d;
        w_iter        = cur.iter;
        w_best        = cur.best;
        w_seed        = cur.seed;
        w_improved    = cur.improved;
        entry_restart = 1'b0;
        go_search     = 1'b0;
        go_close      = 1'b0;
        emit_final    = 1'b0;
        emit_probe    = 1'b0;
        emit_done     = 1'b0;
        search_from   = pgps_pkg::PH_PPLUS;
        probe         = '0;
        cand          = '0;
        improve       = score < cur.best;

        if (cmd == pgps_pkg::CMD_START)
        begin
            nxt.gain_p   = cfg.start_gain_p;
            nxt.gain_d   = cfg.start_gain_d;
            nxt.step_p   = (prod_p > cfg.min_step) ? prod_p : cfg.min_step;
            nxt.step_d   = (prod_d > cfg.min_step) ? prod_d : cfg.min_step;
            nxt.best     = '0;
            nxt.seed     = '0;
            nxt.iter     = '0;
            nxt.improved = 1'b0;
            nxt.parity   = 1'b1;
            nxt.phase    = pgps_pkg::PH_SEED;
            res.finished          = 1'b0;
            res.gain_p            = cfg.start_gain_p;
            res.gain_d            = cfg.start_gain_d;
            res.reverse_direction = 1'b0;
            res_valid             = 1'b1;
        end
        else
        begin
            case (cur.phase)
                pgps_pkg::PH_SEED:
                begin
                    w_best        = score;
                    w_seed        = score;
                    entry_restart = 1'b1;
                end
                pgps_pkg::PH_PPLUS, pgps_pkg::PH_PMINUS:
                begin
                    go_search = 1'b1;
                    if (improve)
                    begin
                        w_best      = score;
                        w_improved  = 1'b1;
                        w_gp        = (cur.phase == pgps_pkg::PH_PPLUS) ?
                                      pgps_pkg::sat_add(cur.gain_p, cur.step_p) :
                                      cur.gain_p - cur.step_p;
                        search_from = pgps_pkg::PH_DPLUS;
                    end
                    else if (cur.phase == pgps_pkg::PH_PPLUS)
                        search_from = pgps_pkg::PH_PMINUS;
                    else
                        search_from = pgps_pkg::PH_DPLUS;
                end
                pgps_pkg::PH_DPLUS, pgps_pkg::PH_DMINUS:
                begin
                    if (improve)
                    begin
                        w_best     = score;
                        w_improved = 1'b1;
                        w_gd       = (cur.phase == pgps_pkg::PH_DPLUS) ?
                                     pgps_pkg::sat_add(cur.gain_d, cur.step_d) :
                                     cur.gain_d - cur.step_d;
                        go_close   = 1'b1;
                    end
                    else if (cur.phase == pgps_pkg::PH_DPLUS)
                    begin
                        go_search   = 1'b1;
                        search_from = pgps_pkg::PH_DMINUS;
                    end
                    else
                        go_close = 1'b1;
                end
                pgps_pkg::PH_DONE:
                    emit_done = 1'b1;
                default:
                    ;
            endcase

            // first iteration after the seed trial
            if (entry_restart)
            begin
                if (w_iter >= cfg.iteration_limit)
                    emit_final = 1'b1;
                else
                begin
                    w_improved = 1'b0;
                    probe      = find_probe(pgps_pkg::PH_PPLUS, w_gp, w_gd, w_sp, w_sd);
                    emit_probe = 1'b1;
                end
            end

            if (go_search)
            begin
                probe = find_probe(search_from, w_gp, w_gd, w_sp, w_sd);
                if (probe.found)
                    emit_probe = 1'b1;
                else
                    go_close = 1'b1;
            end

            // end of iteration: shrink if fruitless, test convergence and limit
            if (go_close)
            begin
                if (!w_improved)
                begin
                    w_sp = prod_p;
                    w_sd = prod_d;
                end
                w_iter = w_iter + 8'd1;
                if (w_sp < cfg.min_step && w_sd < cfg.min_step)
                    emit_final = 1'b1;
                else if (w_iter >= cfg.iteration_limit)
                    emit_final = 1'b1;
                else
                begin
                    w_improved = 1'b0;
                    probe      = find_probe(pgps_pkg::PH_PPLUS, w_gp, w_gd, w_sp, w_sd);
                    emit_probe = 1'b1;
                end
            end

            case (probe.phase)
                pgps_pkg::PH_PPLUS:  cand = pgps_pkg::sat_add(w_gp, w_sp);
                pgps_pkg::PH_PMINUS: cand = w_gp - w_sp;
                pgps_pkg::PH_DPLUS:  cand = pgps_pkg::sat_add(w_gd, w_sd);
                pgps_pkg::PH_DMINUS: cand = w_gd - w_sd;
                default:             cand = w_gd;
            endcase

            if (emit_final || emit_probe)
            begin
                nxt.gain_p   = w_gp;
                nxt.gain_d   = w_gd;
                nxt.step_p   = w_sp;
                nxt.step_d   = w_sd;
                nxt.iter     = w_iter;
                nxt.best     = w_best;
                nxt.seed     = w_seed;
                nxt.improved = w_improved;
                res.best_cost       = w_best;
                res.seed_cost       = w_seed;
                res.iterations_done = w_iter;
                res_valid           = 1'b1;
            end

            if (emit_final)
            begin
                nxt.phase             = pgps_pkg::PH_DONE;
                res.finished          = 1'b1;
                res.gain_p            = w_gp;
                res.gain_d            = w_gd;
                res.reverse_direction = 1'b0;
            end
            else if (emit_probe)
            begin
                nxt.phase             = probe.phase;
                nxt.parity            = ~cur.parity;
                res.finished          = 1'b0;
                res.reverse_direction = cur.parity;
                if (probe.phase == pgps_pkg::PH_PPLUS || probe.phase == pgps_pkg::PH_PMINUS)
                begin
                    res.gain_p = cand;
                    res.gain_d = w_gd;
                end
                else
                begin
                    res.gain_p = w_gp;
                    res.gain_d = cand;
                end
            end

            // repeat the final answer, state untouched
            if (emit_done)
            begin
                res.finished          = 1'b1;
                res.gain_p            = cur.gain_p;
                res.gain_d            = cur.gain_d;
                res.reverse_direction = 1'b0;
                res.best_cost         = cur.best;
                res.seed_cost         = cur.seed;
                res.iterations_done   = cur.iter;
                res_valid             = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/pid_gain_pattern_search.sv @@
`default_nettype none

// Pattern search over a P and a D gain (Q16.16). Send a word with tuser 0 to start a
// search from the start gains; the block answers with a trial request. Return the cost
// of each requested trial as a word with tuser 1; every such word brings back one result
// word: the next gains to try (tuser 0) or, once the steps have converged or the
// iteration limit is hit, the final gains (tuser 1). A score word sent before any start
// gives no result. The block takes one word per cycle while results are drained. A result
// word is registered twice: the accepting edge loads the input register, and the output
// register is loaded from it through the search step logic with its two 32x16 step
// multipliers once the output register is free or draining. A stalled result holds the input register.
// Write configuration only while no search word is in flight.

module pid_gain_pattern_search (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pgps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [31:0]                        cfg_data,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [31:0]                        s_tdata,   // trial_score
    input  wire logic                               s_tuser,   // cmd
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // gain_p[31:0], gain_d[63:32], reverse_direction[64], best_cost[96:65],
    // seed_cost[128:97], iterations_done[136:129], zero[143:137]
    output logic [143:0]                            m_tdata,
    output logic                                    m_tuser    // finished
);

    pgps_pkg::cfg_t    cfg_reg;
    pgps_pkg::state_t  st_reg;
    pgps_pkg::state_t  st_next;
    pgps_pkg::result_t res;
    pgps_pkg::result_t out_res_reg;
    logic              res_valid;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        in_cmd_reg;
    logic [31:0] in_score_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    logic        fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_gain_p    <= pgps_pkg::RST_START_GAIN_P;
            cfg_reg.start_gain_d    <= pgps_pkg::RST_START_GAIN_D;
            cfg_reg.step_fraction   <= pgps_pkg::RST_STEP_FRACTION;
            cfg_reg.min_step        <= pgps_pkg::RST_MIN_STEP;
            cfg_reg.shrink_factor   <= pgps_pkg::RST_SHRINK_FACTOR;
            cfg_reg.iteration_limit <= pgps_pkg::RST_ITERATION_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pgps_pkg::REG_START_GAIN_P:    cfg_reg.start_gain_p    <= cfg_data;
                pgps_pkg::REG_START_GAIN_D:    cfg_reg.start_gain_d    <= cfg_data;
                pgps_pkg::REG_STEP_FRACTION:   cfg_reg.step_fraction   <= cfg_data[15:0];
                pgps_pkg::REG_MIN_STEP:        cfg_reg.min_step        <= cfg_data;
                pgps_pkg::REG_SHRINK_FACTOR:   cfg_reg.shrink_factor   <= cfg_data[15:0];
                pgps_pkg::REG_ITERATION_LIMIT: cfg_reg.iteration_limit <= cfg_data[7:0];
                default:                       ;
            endcase
        end
    end

    // output register free or draining this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = fire && res_valid;
    end

    pgps_step u_step (
        .cur       (st_reg),
        .cfg       (cfg_reg),
        .cmd       (in_cmd_reg),
        .score     (in_score_reg),
        .nxt       (st_next),
        .res       (res),
        .res_valid (res_valid)
    );

    // all-zero state is the idle phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg   <= s_tuser;
            in_score_reg <= s_tdata;
        end
        if (fire && res_valid)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.finished;
    assign m_tdata  = {7'd0,
                       out_res_reg.iterations_done,
                       out_res_reg.seed_cost,
                       out_res_reg.best_cost,
                       out_res_reg.reverse_direction,
                       out_res_reg.gain_d,
                       out_res_reg.gain_p};

    // a final word never carries a direction
    a_final_dir: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[64])
        else $error("final word with reverse direction set");

    // a start always leads to the seed phase with a cleared count
    a_start_seed: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_cmd_reg == pgps_pkg::CMD_START |=>
            st_reg.phase == pgps_pkg::PH_SEED && st_reg.iter == 8'd0)
        else $error("start did not enter seed phase");

    // seeded steps never fall below the minimum step
    a_start_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_cmd_reg == pgps_pkg::CMD_START |=>
            st_reg.step_p >= cfg_reg.min_step && st_reg.step_d >= cfg_reg.min_step)
        else $error("seeded step below minimum");

    // a final result leaves the search in the done phase
    a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid && res.finished |=> st_reg.phase == pgps_pkg::PH_DONE)
        else $error("final result without done phase");

    // each trial request flips the direction for the next one
    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid && !res.finished |=> st_reg.parity == !$past(res.reverse_direction))
        else $error("trial direction did not alternate");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
module testbench;

    typedef struct packed {
        logic        cmd;
        logic [31:0] score;
    } trial_word_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [pgps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]                      cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [31:0]                      s_tdata = '0;
    logic                             s_tuser = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [143:0]                     m_tdata;
    logic                             m_tuser;

    trial_word_t       trial_words[$];
    pgps_pkg::result_t pending_answers[$];
    logic              in_fire = 1'b0;
    logic              cfg_fire = 1'b0;
    int                send_gap_pct = 0;
    int                stall_pct = 0;
    int                mismatches = 0;
    int                words_queued = 0;
    logic [31:0]       score_floor = '0;

    // mirrored registers
    logic [31:0] set_start_p = pgps_pkg::RST_START_GAIN_P;
    logic [31:0] set_start_d = pgps_pkg::RST_START_GAIN_D;
    logic [15:0] set_fraction = pgps_pkg::RST_STEP_FRACTION;
    logic [31:0] set_min_step = pgps_pkg::RST_MIN_STEP;
    logic [15:0] set_shrink = pgps_pkg::RST_SHRINK_FACTOR;
    logic [7:0]  set_limit = pgps_pkg::RST_ITERATION_LIMIT;

    // mirrored search state
    logic [31:0]      gain_p_now = '0;
    logic [31:0]      gain_d_now = '0;
    logic [31:0]      best_now = '0;
    logic [31:0]      seed_score = '0;
    logic [31:0]      step_p_now = '0;
    logic [31:0]      step_d_now = '0;
    logic [7:0]       iter_now = '0;
    pgps_pkg::phase_t search_phase = pgps_pkg::PH_IDLE;
    logic             improved_now = 1'b0;
    logic             parity_now = 1'b0;

    pid_gain_pattern_search DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] frac_scale(input logic [31:0] a, input logic [15:0] f);
        logic [47:0] w;
        w = {16'd0, a} * {32'd0, f};
        return w[47:16];
    endfunction

    function automatic logic [31:0] probe_gain(input logic [2:0] ph);
        case (ph)
            pgps_pkg::PH_PPLUS:  return clamp_add(gain_p_now, step_p_now);
            pgps_pkg::PH_PMINUS: return gain_p_now - step_p_now;
            pgps_pkg::PH_DPLUS:  return clamp_add(gain_d_now, step_d_now);
            default:             return gain_d_now - step_d_now;
        endcase
    endfunction

    // a P gain may not reach zero, a D gain may not go negative
    function automatic logic probe_ok(input logic [2:0] ph);
        case (ph)
            pgps_pkg::PH_PPLUS:  return clamp_add(gain_p_now, step_p_now) != 32'd0;
            pgps_pkg::PH_PMINUS: return gain_p_now > step_p_now;
            pgps_pkg::PH_DPLUS:  return 1'b1;
            default:             return gain_d_now >= step_d_now;
        endcase
    endfunction

    function automatic pgps_pkg::result_t pack_answer(input logic fin, input logic [31:0] p,
                                                      input logic [31:0] d, input logic rev);
        pgps_pkg::result_t a;
        a.finished = fin;
        a.gain_p = p;
        a.gain_d = d;
        a.reverse_direction = rev;
        a.best_cost = best_now;
        a.seed_cost = seed_score;
        a.iterations_done = iter_now;
        return a;
    endfunction

    function automatic pgps_pkg::result_t request_trial(input logic [31:0] p,
                                                        input logic [31:0] d);
        pgps_pkg::result_t a;
        a = pack_answer(1'b0, p, d, parity_now);
        parity_now = ~parity_now;
        return a;
    endfunction

    function automatic pgps_pkg::result_t close_out();
        search_phase = pgps_pkg::PH_DONE;
        return pack_answer(1'b1, gain_p_now, gain_d_now, 1'b0);
    endfunction

    // walk forward to the next legal probe, closing iterations on the way
    function automatic pgps_pkg::result_t next_probe(input logic [2:0] from);
        logic [2:0] ph;
        for (int guard = 0; guard < 600; guard++)
        begin
            if (from == pgps_pkg::PH_PPLUS)
            begin
                if (iter_now >= set_limit)
                    return close_out();
                improved_now = 1'b0;
            end
            for (ph = from; ph <= pgps_pkg::PH_DMINUS; ph++)
            begin
                if (probe_ok(ph))
                begin
                    search_phase = pgps_pkg::phase_t'(ph);
                    if (ph <= pgps_pkg::PH_PMINUS)
                        return request_trial(probe_gain(ph), gain_d_now);
                    return request_trial(gain_p_now, probe_gain(ph));
                end
            end
            if (!improved_now)
            begin
                step_p_now = frac_scale(step_p_now, set_shrink);
                step_d_now = frac_scale(step_d_now, set_shrink);
            end
            iter_now = iter_now + 8'd1;
            if (step_p_now < set_min_step && step_d_now < set_min_step)
                return close_out();
            from = pgps_pkg::PH_PPLUS;
        end
        return close_out();
    endfunction

    function automatic logic next_search_answer(input logic cmd, input logic [31:0] score,
                                                output pgps_pkg::result_t ans);
        logic [31:0] sp;
        logic [31:0] sd;
        logic [2:0]  ph;
        ph = search_phase;
        ans = '0;
        if (cmd == pgps_pkg::CMD_START)
        begin
            gain_p_now = set_start_p;
            gain_d_now = set_start_d;
            sp = frac_scale(set_start_p, set_fraction);
            sd = frac_scale(set_start_d, set_fraction);
            step_p_now = (sp > set_min_step) ? sp : set_min_step;
            step_d_now = (sd > set_min_step) ? sd : set_min_step;
            best_now = '0;
            seed_score = '0;
            iter_now = '0;
            improved_now = 1'b0;
            parity_now = 1'b0;
            search_phase = pgps_pkg::PH_SEED;
            ans = request_trial(gain_p_now, gain_d_now);
            return 1'b1;
        end
        if (ph == pgps_pkg::PH_IDLE || ph > pgps_pkg::PH_DONE)
            return 1'b0;
        if (ph == pgps_pkg::PH_DONE)
        begin
            ans = pack_answer(1'b1, gain_p_now, gain_d_now, 1'b0);
            return 1'b1;
        end
        if (ph == pgps_pkg::PH_SEED)
        begin
            best_now = score;
            seed_score = score;
            ans = next_probe(pgps_pkg::PH_PPLUS);
            return 1'b1;
        end
        if (score < best_now)
        begin
            improved_now = 1'b1;
            if (ph <= pgps_pkg::PH_PMINUS)
            begin
                gain_p_now = probe_gain(ph);
                best_now = score;
                ans = next_probe(pgps_pkg::PH_DPLUS);
            end
            else
            begin
                gain_d_now = probe_gain(ph);
                best_now = score;
                // past the last probe: close the iteration
                ans = next_probe(pgps_pkg::PH_DONE);
            end
            return 1'b1;
        end
        ans = next_probe(ph + 3'd1);
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // driver: present the head word, drop it once taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= (int'($urandom_range(99)) >= stall_pct);
            if (s_tvalid && in_fire)
                void'(trial_words.pop_front());
            if (!s_tvalid || in_fire)
            begin
                if (trial_words.size() != 0 && int'($urandom_range(99)) >= send_gap_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser <= trial_words[0].cmd;
                    s_tdata <= trial_words[0].score;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : answer_check
        pgps_pkg::result_t want;
        pgps_pkg::result_t ans;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
            cfg_fire <= 1'b0;
        end
        else
        begin
            in_fire <= s_tvalid && s_tready;
            cfg_fire <= cfg_valid && cfg_ready;
            if (m_tvalid && m_tready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    check_field("finished", 32'(want.finished), 32'(m_tuser));
                    check_field("gain_p", want.gain_p, m_tdata[31:0]);
                    check_field("gain_d", want.gain_d, m_tdata[63:32]);
                    check_field("reverse_direction", 32'(want.reverse_direction),
                                32'(m_tdata[64]));
                    check_field("best_cost", want.best_cost, m_tdata[96:65]);
                    check_field("seed_cost", want.seed_cost, m_tdata[128:97]);
                    check_field("iterations_done", 32'(want.iterations_done),
                                32'(m_tdata[136:129]));
                    check_field("pad", 32'd0, 32'(m_tdata[143:137]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (next_search_answer(s_tuser, s_tdata, ans))
                    pending_answers.push_back(ans);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pgps_pkg::REG_START_GAIN_P:    set_start_p = cfg_data;
                    pgps_pkg::REG_START_GAIN_D:    set_start_d = cfg_data;
                    pgps_pkg::REG_STEP_FRACTION:   set_fraction = cfg_data[15:0];
                    pgps_pkg::REG_MIN_STEP:        set_min_step = cfg_data;
                    pgps_pkg::REG_SHRINK_FACTOR:   set_shrink = cfg_data[15:0];
                    pgps_pkg::REG_ITERATION_LIMIT: set_limit = cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    task automatic add_word(input logic cmd, input logic [31:0] score);
        trial_word_t w;
        w.cmd = cmd;
        w.score = score;
        trial_words.push_back(w);
        words_queued++;
    endtask

    // mostly worse or equal scores so steps shrink; floor tracks the best so far
    task automatic add_scores(input int n);
        logic [31:0] s;
        int          pick;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 35 && score_floor != 0)
                s = score_floor - $urandom_range((score_floor >> 3) + 1, 1);
            else if (pick < 45)
                s = score_floor;
            else if (pick < 90)
            begin
                s = score_floor + $urandom_range(32'h00FF_FFFF, 1);
                if (s < score_floor)
                    s = '1;
            end
            else
                s = $urandom;
            if (s < score_floor)
                score_floor = s;
            add_word(pgps_pkg::CMD_SCORE, s);
        end
    endtask

    task automatic add_search(input int n);
        logic [31:0] seed;
        add_word(pgps_pkg::CMD_START, $urandom);
        if ($urandom_range(3) == 0)
            seed = $urandom;
        else
            seed = $urandom_range(32'h7FFF_FFFF, 32'h0001_0000);
        score_floor = seed;
        add_word(pgps_pkg::CMD_SCORE, seed);
        add_scores(n);
    endtask

    task automatic wait_drained();
        while (trial_words.size() != 0 || pending_answers.size() != 0)
            @(negedge clk);
        // a score while idle gives no word back; let it clear the pipeline
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(input logic [pgps_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [31:0] gp, input logic [31:0] gd,
                                 input logic [15:0] fr, input logic [31:0] mn,
                                 input logic [15:0] sh, input logic [7:0] lim);
        write_register(pgps_pkg::REG_START_GAIN_P, gp);
        write_register(pgps_pkg::REG_START_GAIN_D, gd);
        write_register(pgps_pkg::REG_STEP_FRACTION, {16'd0, fr});
        write_register(pgps_pkg::REG_MIN_STEP, mn);
        write_register(pgps_pkg::REG_SHRINK_FACTOR, {16'd0, sh});
        write_register(pgps_pkg::REG_ITERATION_LIMIT, {24'd0, lim});
    endtask

    task automatic load_random_settings();
        logic [31:0] gp;
        logic [31:0] gd;
        logic [31:0] mn;
        logic [15:0] fr;
        logic [15:0] sh;
        logic [7:0]  lim;
        case ($urandom_range(3))
            0: gp = '0;
            1: gp = '1;
            default: gp = $urandom_range(32'h0010_0000, 1);
        endcase
        case ($urandom_range(3))
            0: gd = '0;
            1: gd = $urandom;
            default: gd = $urandom_range(32'h0010_0000, 0);
        endcase
        case ($urandom_range(3))
            0: fr = '0;
            1: fr = '1;
            default: fr = 16'($urandom_range(16'hFFFF, 0));
        endcase
        case ($urandom_range(3))
            0: mn = '0;
            1: mn = '1;
            default: mn = $urandom_range(2000, 1);
        endcase
        case ($urandom_range(3))
            0: sh = '0;
            1: sh = '1;
            default: sh = 16'($urandom_range(61000, 16384));
        endcase
        case ($urandom_range(3))
            0: lim = '0;
            1: lim = '1;
            default: lim = 8'($urandom_range(30, 1));
        endcase
        load_settings(gp, gd, fr, mn, sh, lim);
    endtask

    initial
    begin : run_stimulus
        int target;
        int pick;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // scores before any start are dropped
        add_word(pgps_pkg::CMD_SCORE, 32'hFFFF_FFFF);
        add_word(pgps_pkg::CMD_SCORE, 32'h0000_0000);
        add_word(pgps_pkg::CMD_START, 32'hFFFF_FFFF);
        add_word(pgps_pkg::CMD_SCORE, 32'h0064_0000);
        add_word(pgps_pkg::CMD_SCORE, 32'h0065_0000);
        add_word(pgps_pkg::CMD_SCORE, 32'h0064_0000);
        add_word(pgps_pkg::CMD_SCORE, 32'h0010_0000);
        add_word(pgps_pkg::CMD_SCORE, 32'h0008_0000);
        add_word(pgps_pkg::CMD_SCORE, 32'hFFFF_FFFF);
        // restart mid-search; a zero seed can never be beaten, so steps shrink to the end
        add_word(pgps_pkg::CMD_START, 32'h0000_0000);
        add_word(pgps_pkg::CMD_SCORE, 32'h0000_0000);
        repeat (17) add_word(pgps_pkg::CMD_SCORE, 32'hFFFF_FFFF);
        score_floor = '0;

        for (int seg = 0; seg < 8; seg++)
        begin
            wait_drained();
            case (seg)
                0: ;
                1: load_settings('1, '1, 16'hFFFF, '1, 16'hFFFF, 8'hFF);
                2: load_settings('0, '0, 16'h0000, '0, 16'h0000, 8'h00);
                default: load_random_settings();
            endcase
            case (seg % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 88; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 88; end
                default: begin send_gap_pct = 24; stall_pct = 24; end
            endcase
            // carry on with the search left over from the last setting
            if (seg != 0)
                add_scores($urandom_range(4));
            target = words_queued + 165;
            while (words_queued < target)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                    add_word(pgps_pkg::CMD_START, $urandom);
                else if (pick < 10)
                    add_word(pgps_pkg::CMD_SCORE, $urandom);
                else if (pick < 20)
                    add_search($urandom_range(120, 40));
                else
                    add_search($urandom_range(30));
            end
        end
        wait_drained();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hdl/pgps_pkg.sv
hdl/pgps_step.sv
hdl/pid_gain_pattern_search.sv
test/testbench.sv
